// ----- rtl/rbf_interpolant_evaluate_core_macros.svh -----
// Assertion macros shared by the RBF interpolant evaluator RTL.
// Needs a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef RBF_INTERPOLANT_EVALUATE_CORE_MACROS_SVH
`define RBF_INTERPOLANT_EVALUATE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBFIE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBFIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rbfie_pkg.sv -----
// Shared types and constants for the RBF interpolant evaluator.
// No dependencies; used by every module of the block.
`default_nettype none

package rbfie_pkg;

	localparam int MAX_CENTERS_DEF      = 64;
	localparam int KERNEL_FRAC_BITS_DEF = 16;

	localparam int COORD_W  = 24;
	localparam int WEIGHT_W = 32;
	localparam int OUT_W    = 48;
	localparam int ACC_W    = 56;
	localparam int LOG_FRAC = 26;

	// log10(2) in Q0.32
	localparam logic [30:0] LOG10_OF_2 = 31'h4D104D42;

	localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0] OUT_MIN = 48'h8000_0000_0000;

	// Commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_CENTER_COUNT = 3'd0;
	localparam logic [2:0] REG_AFFINE_CONST = 3'd1;
	localparam logic [2:0] REG_AFFINE_X     = 3'd2;
	localparam logic [2:0] REG_AFFINE_Y     = 3'd3;
	localparam logic [2:0] REG_AFFINE_Z     = 3'd4;
	localparam logic [2:0] REG_MODEL_READY  = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic signed [WEIGHT_W-1:0] w;
	} center_t;

	typedef struct packed {
		logic                       last;
		logic signed [WEIGHT_W-1:0] weight;
	} kern_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SUM
	} ctl_state_t;

endpackage

`default_nettype wire

// ----- rtl/rbfie_store.sv -----
// Center store: one write port, one registered read port.
// Depends on rbfie_pkg for the center entry type.
`default_nettype none

module rbfie_store #(
	parameter int DEPTH = rbfie_pkg::MAX_CENTERS_DEF,
	parameter int AW    = 6
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire rbfie_pkg::center_t  wr_data,
	input  wire logic [AW-1:0]       rd_addr,
	output rbfie_pkg::center_t       rd_data
);

	rbfie_pkg::center_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/rbfie_kernel.sv -----
// Kernel pipeline: squared distance, log2 by normalize and repeated squaring,
// scale to log10, then a digit-per-stage square root. Depends on rbfie_pkg.
`default_nettype none

module rbfie_kernel #(
	parameter int KFRAC = rbfie_pkg::KERNEL_FRAC_BITS_DEF,
	localparam int KW   = KFRAC + 3
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	input  wire rbfie_pkg::kern_tag_t                    in_tag,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    qx,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    qy,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    qz,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    cx,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    cy,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]    cz,
	output logic                                         out_valid,
	output rbfie_pkg::kern_tag_t                         out_tag,
	output logic [KW-1:0]                                kern
);

	localparam int DW   = rbfie_pkg::COORD_W + 1;
	localparam int SQW  = 2 * DW;
	localparam int VW   = 53;
	localparam int NNRM = 6;
	localparam int NLOG = rbfie_pkg::LOG_FRAC;
	localparam int SH   = 58 - 2 * KFRAC;
	localparam int RW   = KW + 3;
	localparam int TOT  = 3 + NNRM + NLOG + 1 + KW;

	// valid and tag travel alongside the data
	logic                 vld_p [TOT];
	rbfie_pkg::kern_tag_t tag_p [TOT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < TOT; g++) begin
				vld_p[g] <= 1'b0;
			end
		end else begin
			vld_p[0] <= in_valid;
			for (int g = 1; g < TOT; g++) begin
				vld_p[g] <= vld_p[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_p[0] <= in_tag;
		for (int g = 1; g < TOT; g++) begin
			tag_p[g] <= tag_p[g-1];
		end
	end

	// coordinate differences
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= {cx[rbfie_pkg::COORD_W-1], cx} - {qx[rbfie_pkg::COORD_W-1], qx};
		dy_s1 <= {cy[rbfie_pkg::COORD_W-1], cy} - {qy[rbfie_pkg::COORD_W-1], qy};
		dz_s1 <= {cz[rbfie_pkg::COORD_W-1], cz} - {qz[rbfie_pkg::COORD_W-1], qz};
	end

	// squares
	logic signed [SQW-1:0] sqx, sqy, sqz;
	logic [SQW-1:0]        sqx_s2, sqy_s2, sqz_s2;

	assign sqx = SQW'(dx_s1) * SQW'(dx_s1);
	assign sqy = SQW'(dy_s1) * SQW'(dy_s1);
	assign sqz = SQW'(dz_s1) * SQW'(dz_s1);

	always_ff @(posedge clk) begin
		sqx_s2 <= sqx;
		sqy_s2 <= sqy;
		sqz_s2 <= sqz;
	end

	// v = s + 1.0, then normalize msb to the top
	logic [VW-1:0] nrm_s [NNRM+1];
	logic [5:0]    pe_s  [NNRM+1];

	always_ff @(posedge clk) begin
		nrm_s[0] <= VW'(sqx_s2) + VW'(sqy_s2) + VW'(sqz_s2) + VW'(17'h10000);
		pe_s[0]  <= 6'(VW - 1);
	end

	for (genvar j = 0; j < NNRM; j++) begin : g_nrm
		localparam int NSH = 32 >> j;
		always_ff @(posedge clk) begin
			if (nrm_s[j][VW-1 -: NSH] == {NSH{1'b0}}) begin
				nrm_s[j+1] <= nrm_s[j] << NSH;
				pe_s[j+1]  <= pe_s[j] - 6'(NSH);
			end else begin
				nrm_s[j+1] <= nrm_s[j];
				pe_s[j+1]  <= pe_s[j];
			end
		end
	end

	// fractional log2 bits, one squaring per stage
	logic [31:0]     lm_s  [NLOG];
	logic [5:0]      lip_s [NLOG];
	logic [NLOG-1:0] lfr_s [NLOG];

	for (genvar j = 0; j < NLOG; j++) begin : g_log
		logic [31:0]     m_in;
		logic [5:0]      ip_in;
		logic [NLOG-1:0] f_in;
		logic [63:0]     msq;
		logic [32:0]     mt;

		if (j == 0) begin : g_first
			assign m_in  = nrm_s[NNRM][VW-1 -: 32];
			assign ip_in = pe_s[NNRM] - 6'd16;
			assign f_in  = '0;
		end else begin : g_next
			assign m_in  = lm_s[j-1];
			assign ip_in = lip_s[j-1];
			assign f_in  = lfr_s[j-1];
		end

		assign msq = {32'd0, m_in} * {32'd0, m_in};
		assign mt  = msq[63:31];

		always_ff @(posedge clk) begin
			lip_s[j] <= ip_in;
			if (mt[32]) begin
				lm_s[j]  <= mt[32:1];
				lfr_s[j] <= {f_in[NLOG-2:0], 1'b1};
			end else begin
				lm_s[j]  <= mt[31:0];
				lfr_s[j] <= {f_in[NLOG-2:0], 1'b0};
			end
		end
	end

	// log10 = log2 * log10(2), down to Q.(2F)
	logic [63:0]     l10_prod;
	logic [2*KW-1:0] l10_s;

	assign l10_prod = 64'({lip_s[NLOG-1], lfr_s[NLOG-1]}) * 64'(rbfie_pkg::LOG10_OF_2);

	always_ff @(posedge clk) begin
		l10_s <= l10_prod[SH +: 2*KW];
	end

	// integer square root, one result bit per stage
	logic [2*KW-1:0] sr_x   [KW];
	logic [RW-1:0]   sr_rem [KW];
	logic [KW-1:0]   sr_res [KW];

	for (genvar j = 0; j < KW; j++) begin : g_sqrt
		logic [2*KW-1:0] x_in;
		logic [RW-1:0]   rem_in;
		logic [KW-1:0]   res_in;
		logic [RW-1:0]   remsh;
		logic [RW-1:0]   trial;
		logic            ge;

		if (j == 0) begin : g_first
			assign x_in   = l10_s;
			assign rem_in = '0;
			assign res_in = '0;
		end else begin : g_next
			assign x_in   = sr_x[j-1];
			assign rem_in = sr_rem[j-1];
			assign res_in = sr_res[j-1];
		end

		assign remsh = {rem_in[RW-3:0], x_in[2*KW-1-2*j -: 2]};
		assign trial = RW'({res_in, 2'b01});
		assign ge    = (remsh >= trial);

		always_ff @(posedge clk) begin
			sr_x[j]   <= x_in;
			sr_rem[j] <= ge ? (remsh - trial) : remsh;
			sr_res[j] <= {res_in[KW-2:0], ge};
		end
	end

	assign out_valid = vld_p[TOT-1];
	assign out_tag   = tag_p[TOT-1];
	assign kern      = sr_res[KW-1];

endmodule

`default_nettype wire

// ----- rtl/rbf_interpolant_evaluate_core.sv -----
// RBF interpolant evaluator. A write command (cmd 0) stores one center and returns nothing;
// busy stays low. An evaluate command (cmd 1) holds busy while the centers below center_count
// are read from the center store one per cycle and sent down the kernel pipeline, which is
// 36 + KERNEL_FRAC_BITS + 3 stages deep (26 of them log squaring stages); the weighted terms
// are summed, the affine term added and the result saturated. The result is registered on
// value and saturated as done goes high for exactly one cycle; done cannot be held off, and
// value and saturated keep the result until the next one. With model_ready low the result is zero.
// Depends on rbfie_pkg, rbfie_store, rbfie_kernel and the assertion macro header.
`default_nettype none

`include "rbf_interpolant_evaluate_core_macros.svh"

module rbf_interpolant_evaluate_core #(
	parameter int MAX_CENTERS      = rbfie_pkg::MAX_CENTERS_DEF,
	parameter int KERNEL_FRAC_BITS = rbfie_pkg::KERNEL_FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   cmd,
	input  wire logic [5:0]                             entry_index,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]   px,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]   py,
	input  wire logic signed [rbfie_pkg::COORD_W-1:0]   pz,
	input  wire logic signed [rbfie_pkg::WEIGHT_W-1:0]  weight,
	input  wire logic                                   cfg_we,
	input  wire logic [2:0]                             cfg_index,
	input  wire logic [31:0]                            cfg_data,
	output logic                                        done,
	output logic signed [rbfie_pkg::OUT_W-1:0]          value,
	output logic                                        saturated
);

	localparam int AW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CNTW  = $clog2(MAX_CENTERS + 1);
	localparam int KW    = KERNEL_FRAC_BITS + 3;
	localparam int PW    = rbfie_pkg::WEIGHT_W + KW + 1;
	localparam int ACCW  = rbfie_pkg::ACC_W;
	localparam int OW    = rbfie_pkg::OUT_W;

	// configuration registers
	logic [6:0]         center_count_q;
	logic signed [31:0] aff_c_q, aff_x_q, aff_y_q, aff_z_q;
	logic               model_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_count_q <= '0;
			aff_c_q        <= '0;
			aff_x_q        <= '0;
			aff_y_q        <= '0;
			aff_z_q        <= '0;
			model_ready_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbfie_pkg::REG_CENTER_COUNT: center_count_q <= cfg_data[6:0];
				rbfie_pkg::REG_AFFINE_CONST: aff_c_q        <= cfg_data;
				rbfie_pkg::REG_AFFINE_X:     aff_x_q        <= cfg_data;
				rbfie_pkg::REG_AFFINE_Y:     aff_y_q        <= cfg_data;
				rbfie_pkg::REG_AFFINE_Z:     aff_z_q        <= cfg_data;
				rbfie_pkg::REG_MODEL_READY:  model_ready_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// command transfer
	rbfie_pkg::ctl_state_t state_q, state_d;
	logic accept, eval_acc, wr_acc;

	assign accept   = start && !busy;
	assign eval_acc = accept && (cmd == rbfie_pkg::CMD_EVAL);
	assign wr_acc   = accept && (cmd == rbfie_pkg::CMD_WRITE) &&
		(int'(entry_index) < MAX_CENTERS);

	// effective center count for this evaluation
	logic [CNTW-1:0] n_eff;

	always_comb begin
		if (!model_ready_q) begin
			n_eff = '0;
		end else if (int'(center_count_q) > MAX_CENTERS) begin
			n_eff = CNTW'(MAX_CENTERS);
		end else begin
			n_eff = CNTW'(center_count_q);
		end
	end

	// latched query
	logic signed [rbfie_pkg::COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [CNTW-1:0]                      n_q;
	logic                                 ready_q;

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			qx_q    <= px;
			qy_q    <= py;
			qz_q    <= pz;
			n_q     <= n_eff;
			ready_q <= model_ready_q;
		end
	end

	// walk counter
	logic [CNTW-1:0] cnt_q;
	logic            issue, last_issue, fin;

	assign last_issue = (cnt_q == n_q - CNTW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (eval_acc) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	// center store
	rbfie_pkg::center_t wr_data, rd_data;

	assign wr_data = '{x: px, y: py, z: pz, w: weight};

	rbfie_store #(
		.DEPTH (MAX_CENTERS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_acc),
		.wr_addr (AW'(entry_index)),
		.wr_data (wr_data),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// valid and last aligned with the registered read
	logic rd_v_q, rd_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q    <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			rd_v_q    <= issue;
			rd_last_q <= issue && last_issue;
		end
	end

	// kernel pipeline
	rbfie_pkg::kern_tag_t in_tag, k_tag;
	logic                 k_valid;
	logic [KW-1:0]        k_val;

	assign in_tag = '{last: rd_last_q, weight: rd_data.w};

	rbfie_kernel #(
		.KFRAC (KERNEL_FRAC_BITS)
	) u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q),
		.in_tag    (in_tag),
		.qx        (qx_q),
		.qy        (qy_q),
		.qz        (qz_q),
		.cx        (rd_data.x),
		.cy        (rd_data.y),
		.cz        (rd_data.z),
		.out_valid (k_valid),
		.out_tag   (k_tag),
		.kern      (k_val)
	);

	// weight times kernel
	logic signed [PW-1:0] prod_s;
	logic signed [PW-1:0] prod_sh;
	logic                 pv_s, plast_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s    <= 1'b0;
			plast_s <= 1'b0;
		end else begin
			pv_s    <= k_valid;
			plast_s <= k_valid && k_tag.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s <= PW'(k_tag.weight) * PW'($signed({1'b0, k_val}));
	end

	assign prod_sh = prod_s >>> KERNEL_FRAC_BITS;

	// term accumulator
	logic signed [ACCW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			acc_q <= '0;
		end else if (pv_s) begin
			acc_q <= acc_q + ACCW'(prod_sh);
		end
	end

	// affine term from the latched query
	logic signed [55:0]     ax_q, ay_q, az_q;
	logic signed [ACCW-1:0] aff_q;

	always_ff @(posedge clk) begin
		ax_q  <= 56'(aff_x_q) * 56'(qx_q);
		ay_q  <= 56'(aff_y_q) * 56'(qy_q);
		az_q  <= 56'(aff_z_q) * 56'(qz_q);
		aff_q <= ACCW'(aff_c_q) + ACCW'(ax_q >>> 8) + ACCW'(ay_q >>> 8) + ACCW'(az_q >>> 8);
	end

	// final sum and clip
	logic signed [ACCW-1:0] total;
	logic                   ovf;
	logic [OW-1:0]          clipped;

	assign total   = acc_q + aff_q;
	assign ovf     = (total[ACCW-1:OW-1] != {(ACCW-OW+1){total[OW-1]}});
	assign clipped = ovf ? (total[ACCW-1] ? rbfie_pkg::OUT_MIN : rbfie_pkg::OUT_MAX)
		: total[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			value     <= ready_q ? clipped : '0;
			saturated <= ready_q && ovf;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbfie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbfie_pkg::ST_IDLE: begin
				if (eval_acc) state_d = rbfie_pkg::ST_WALK;
			end
			rbfie_pkg::ST_WALK: begin
				if (n_q == '0 || last_issue) state_d = rbfie_pkg::ST_DRAIN;
			end
			rbfie_pkg::ST_DRAIN: begin
				if (n_q == '0 || plast_s) state_d = rbfie_pkg::ST_SUM;
			end
			rbfie_pkg::ST_SUM: begin
				state_d = rbfie_pkg::ST_IDLE;
			end
			default: state_d = rbfie_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = (state_q != rbfie_pkg::ST_IDLE);
		issue = (state_q == rbfie_pkg::ST_WALK) && (n_q != '0);
		fin   = (state_q == rbfie_pkg::ST_SUM);
	end

	// checks
	`RBFIE_ASSERT_NEXT(a_eval_goes_busy, eval_acc, busy, "evaluate accepted but block not busy")
	`RBFIE_ASSERT_NOW(a_done_after_sum, done, $past(state_q) == rbfie_pkg::ST_SUM, "done without final sum")
	`RBFIE_ASSERT_NOW(a_term_in_window, pv_s, state_q == rbfie_pkg::ST_WALK || state_q == rbfie_pkg::ST_DRAIN, "term arrived outside an evaluation")

endmodule

`default_nettype wire

// ----- tb/rbf_interpolant_evaluate_core_tb.sv -----
// Self-checking testbench for rbf_interpolant_evaluate_core: directed and random center
// writes and evaluations under several register settings, checked against a local predictor.
// Depends on rbfie_pkg and the RTL of the block.
`timescale 1ns / 1ps

typedef struct {
	logic                                      cmd;
	logic [5:0]                                idx;
	logic signed [rbfie_pkg::COORD_W-1:0]      x;
	logic signed [rbfie_pkg::COORD_W-1:0]      y;
	logic signed [rbfie_pkg::COORD_W-1:0]      z;
	logic signed [rbfie_pkg::WEIGHT_W-1:0]     w;
} rbf_item_t;

typedef struct {
	logic signed [rbfie_pkg::OUT_W-1:0] value;
	logic                               sat;
} rbf_result_t;

// Interpolant predictor and queue of predicted evaluation results
class rbf_scoreboard;
	rbfie_pkg::center_t centers[64];
	int unsigned        n_centers;
	longint             a_const, a_x, a_y, a_z;
	bit                 ready;
	rbf_result_t        pending_q[$];
	int                 errors;
	int                 n_evals, n_writes, n_sat;

	function new();
		foreach (centers[i]) centers[i] = '0;
		n_centers = 0;
		a_const = 0; a_x = 0; a_y = 0; a_z = 0;
		ready = 0;
		errors = 0;
		n_evals = 0; n_writes = 0; n_sat = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] data);
		case (idx)
			rbfie_pkg::REG_CENTER_COUNT: n_centers = data[6:0];
			rbfie_pkg::REG_AFFINE_CONST: a_const = longint'($signed(data));
			rbfie_pkg::REG_AFFINE_X:     a_x = longint'($signed(data));
			rbfie_pkg::REG_AFFINE_Y:     a_y = longint'($signed(data));
			rbfie_pkg::REG_AFFINE_Z:     a_z = longint'($signed(data));
			rbfie_pkg::REG_MODEL_READY:  ready = data[0];
			default: ;
		endcase
	endfunction

	// sqrt(log10(s + 1)), s in Q.16, unsigned Q2.16 result
	function bit [63:0] kernel_of(bit [63:0] s);
		bit [63:0] v, m, fr, l2, l10, res, b, xr;
		int p;
		v = s + 64'd65536;
		p = 0;
		fr = 0;
		for (int i = 0; i < 64; i++) if (v[i]) p = i;
		if (p >= 31) m = v >> (p - 31);
		else m = v << (31 - p);
		for (int i = 0; i < 26; i++) begin
			m = (m * m) >> 31;
			fr = fr << 1;
			if (m >= 64'h1_0000_0000) begin
				fr = fr | 64'd1;
				m = m >> 1;
			end
		end
		l2 = (64'(p - 16) << 26) | fr;
		l10 = (l2 * 64'h4D104D42) >> 26;
		// floor integer square root
		xr = l10;
		res = 0;
		b = 64'd1 << 62;
		while (b > xr) b = b >> 2;
		while (b != 0) begin
			if (xr >= res + b) begin
				xr = xr - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Note one accepted transfer and queue the result it causes
	function void note_input(rbf_item_t it);
		rbf_result_t r;
		longint acc, qx, qy, qz, dx, dy, dz, wk;
		bit [63:0] s;
		int unsigned n;
		if (it.cmd == rbfie_pkg::CMD_WRITE) begin
			centers[it.idx].x = it.x;
			centers[it.idx].y = it.y;
			centers[it.idx].z = it.z;
			centers[it.idx].w = it.w;
			n_writes++;
			return;
		end
		n_evals++;
		r.value = '0;
		r.sat = 1'b0;
		if (ready) begin
			qx = it.x; qy = it.y; qz = it.z;
			n = (n_centers > 64) ? 64 : n_centers;
			acc = 0;
			for (int i = 0; i < n; i++) begin
				dx = qx - longint'(centers[i].x);
				dy = qy - longint'(centers[i].y);
				dz = qz - longint'(centers[i].z);
				s = dx * dx + dy * dy + dz * dz;
				wk = longint'(centers[i].w) * longint'(kernel_of(s));
				acc += wk >>> 16;
			end
			acc += a_const;
			acc += (a_x * qx) >>> 8;
			acc += (a_y * qy) >>> 8;
			acc += (a_z * qz) >>> 8;
			if (acc > 64'sh7FFF_FFFF_FFFF) begin
				acc = 64'sh7FFF_FFFF_FFFF;
				r.sat = 1'b1;
			end else if (acc < -64'sh8000_0000_0000) begin
				acc = -64'sh8000_0000_0000;
				r.sat = 1'b1;
			end
			r.value = acc[47:0];
		end
		if (r.sat) n_sat++;
		pending_q.push_back(r);
	endfunction

	function void check_result(logic [47:0] value, logic sat);
		rbf_result_t e;
		if (pending_q.size() == 0) begin
			$error("result with no evaluation pending: value=%h saturated=%b", value, sat);
			errors++;
			return;
		end
		e = pending_q.pop_front();
		if (value !== e.value) begin
			$error("value: expected %h, got %h", e.value, value);
			errors++;
		end
		if (sat !== e.sat) begin
			$error("saturated: expected %b, got %b", e.sat, sat);
			errors++;
		end
	endfunction
endclass

module rbf_interpolant_evaluate_core_tb;

	localparam int LIMIT = 2_000_000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cmd;
	logic [5:0]        entry_index;
	logic signed [23:0] px, py, pz;
	logic signed [31:0] weight;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [31:0]       cfg_data;
	logic              done;
	logic signed [47:0] value;
	logic              saturated;

	rbf_scoreboard sb;
	int unsigned   cycles;

	rbf_interpolant_evaluate_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.entry_index(entry_index), .px(px), .py(py), .pz(pz), .weight(weight),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .value(value), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result monitor: values before the edge's updates
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(value, saturated);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one transfer, after a random gap; start stays high afterwards
	task automatic send(rbf_item_t it);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= it.cmd;
		entry_index <= it.idx;
		px          <= it.x;
		py          <= it.y;
		pz          <= it.z;
		weight      <= it.w;
		do @(posedge clk); while (busy);
		sb.note_input(it);
	endtask

	// wait until every result is in and the block has settled
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() > 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register write; the task returns with cfg_we low so writes never overlap
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic set_affine(logic [31:0] c, logic [31:0] ax, logic [31:0] ay,
			logic [31:0] az);
		write_reg(rbfie_pkg::REG_AFFINE_CONST, c);
		write_reg(rbfie_pkg::REG_AFFINE_X, ax);
		write_reg(rbfie_pkg::REG_AFFINE_Y, ay);
		write_reg(rbfie_pkg::REG_AFFINE_Z, az);
	endtask

	function automatic rbf_item_t make(logic c, logic [5:0] idx, logic [23:0] x,
			logic [23:0] y, logic [23:0] z, logic [31:0] w);
		rbf_item_t it;
		it.cmd = c; it.idx = idx; it.x = x; it.y = y; it.z = z; it.w = w;
		return it;
	endfunction

	// coordinate: full range or near the origin
	function automatic logic [23:0] rand_coord();
		if ($urandom_range(0, 2) == 0) return 24'($urandom);
		return 24'($signed($urandom_range(0, 4095)) - 2048);
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			3: return 32'd0;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic rbf_item_t rand_item();
		rbf_item_t it;
		it.cmd = ($urandom_range(0, 9) < 3) ? rbfie_pkg::CMD_WRITE : rbfie_pkg::CMD_EVAL;
		it.idx = 6'($urandom);
		it.x = rand_coord();
		it.y = rand_coord();
		it.z = rand_coord();
		it.w = ($urandom_range(0, 1)) ? 32'($urandom)
			: 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		return it;
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = rbfie_pkg::CMD_WRITE;
		entry_index = '0;
		px = '0; py = '0; pz = '0;
		weight = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot with model not ready; first slots hold the extremes
		send(make(rbfie_pkg::CMD_WRITE, 6'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			32'h7FFF_FFFF));
		send(make(rbfie_pkg::CMD_WRITE, 6'd1, 24'h800000, 24'h800000, 24'h800000,
			32'h8000_0000));
		send(make(rbfie_pkg::CMD_WRITE, 6'd2, 24'h0, 24'h0, 24'h0, 32'h0001_0000));
		for (int i = 3; i < 64; i++) begin
			rbf_item_t it;
			it = rand_item();
			it.cmd = rbfie_pkg::CMD_WRITE;
			it.idx = 6'(i);
			send(it);
		end
		// not ready: zero result
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h123456, 24'h0, 24'h7FFFFF, 32'h0));
		drain();

		write_reg(rbfie_pkg::REG_MODEL_READY, 32'd1);
		write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'd0);
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h000100, 24'h0, 24'h0, 32'h0));
		drain();
		// count beyond capacity, indexes beyond the register list
		write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'd100);
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'hFFFF_FFFF);
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h0, 24'h0, 24'h0, 32'h0));
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h0));
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h800000, 24'h800000, 24'h800000, 32'h0));
		drain();
		// affine extremes drive the sum into saturation both ways
		write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'd64);
		set_affine(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h800000, 24'h800000, 24'h800000, 32'h0));
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h0));
		drain();
		set_affine(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h7FFFFF, 24'h800000, 24'h000001, 32'h0));
		send(make(rbfie_pkg::CMD_EVAL, 6'd0, 24'h800000, 24'h800000, 24'h800000, 32'h0));
		drain();

		// random phases, each under new register settings
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 4))
				0: write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'd0);
				1: write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'd64);
				2: write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'($urandom_range(65, 127)));
				default: write_reg(rbfie_pkg::REG_CENTER_COUNT, 32'($urandom_range(1, 64)));
			endcase
			set_affine(rand_coef(), rand_coef(), rand_coef(), rand_coef());
			write_reg(rbfie_pkg::REG_MODEL_READY,
				($urandom_range(0, 9) == 0) ? 32'd0 : 32'd1);
			for (int k = 0; k < 100; k++) send(rand_item());
			drain();
		end

		repeat (70) @(posedge clk);
		$display("Covered %0d evaluations (%0d saturated) and %0d center writes",
			sb.n_evals, sb.n_sat, sb.n_writes);
		$display("over directed extremes and eight random register settings.");
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
